// File: src/dltq_pkg.sv
`default_nettype none
package dltq_pkg;
  localparam int DefMaxTimers = 16;
  localparam int DefTickBits  = 32;
  localparam int SlotBits     = 4;
  localparam int ProcBits     = 12;
  localparam int ExpiryBits   = 32;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WALK,
    S_ADD_SHIFT,
    S_ADD_DONE,
    S_DEL_FIND,
    S_DEL_FIX,
    S_DEL_SHIFT,
    S_TICK_DEC,
    S_TICK_CHECK,
    S_TICK_SHIFT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic walk_step;
    logic add_check;
    logic shift_up;
    logic insert;
    logic find_step;
    logic del_fix;
    logic shift_down;
    logic tick_dec;
    logic emit_ack;
    logic emit_wake;
  } cmd_t;

  typedef struct packed {
    logic    queued;
    logic    zero_exp;
    logic    full;
    logic    empty;
    logic    walk_end;
    logic    walk_stop;
    logic    shift_end;
    logic    find_hit;
    logic    head_zero;
    logic    out_busy;
  } stat_t;
endpackage
`default_nettype wire

// File: src/dltq_if.sv
`default_nettype none
interface dltq_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   operation;
  logic [dltq_pkg::SlotBits-1:0]   timer_slot;
  logic [dltq_pkg::ProcBits-1:0]   owner_process;
  logic [dltq_pkg::ExpiryBits-1:0] expiry_ticks;
  modport source (output valid, operation, timer_slot, owner_process, expiry_ticks,
                  input ready);
  modport sink (input valid, operation, timer_slot, owner_process, expiry_ticks,
                output ready);
endinterface

interface dltq_out_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [1:0]                   status;
  logic [dltq_pkg::SlotBits-1:0] expired_slot;
  logic [dltq_pkg::ProcBits-1:0] wake_process;
  logic                         last;
  modport source (output valid, kind, status, expired_slot, wake_process, last,
                  input ready);
  modport sink (input valid, kind, status, expired_slot, wake_process, last,
                output ready);
endinterface
`default_nettype wire

// File: src/dltq_ctrl.sv
`default_nettype none
module dltq_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     op,
  input  wire dltq_pkg::stat_t st,
  output dltq_pkg::cmd_t      cmd
);
  import dltq_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (op)
            OP_ADD:  state_next = S_ADD_DONE;
            OP_DEL:  state_next = S_DEL_FIND;
            OP_TICK: state_next = S_TICK_DEC;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_ADD_DONE: begin
        if (st.zero_exp || st.queued || st.full) state_next = S_OUT;
        else state_next = S_ADD_WALK;
      end
      S_ADD_WALK:  if (st.walk_end || st.walk_stop) state_next = S_ADD_SHIFT;
      S_ADD_SHIFT: if (st.shift_end) state_next = S_OUT;
      S_DEL_FIND: begin
        if (!st.queued || st.walk_end) state_next = S_OUT;
        else if (st.find_hit) state_next = S_DEL_FIX;
      end
      S_DEL_FIX:   state_next = S_DEL_SHIFT;
      S_DEL_SHIFT: if (st.shift_end) state_next = S_OUT;
      S_TICK_DEC:  state_next = st.empty ? S_IDLE : S_TICK_CHECK;
      S_TICK_CHECK: begin
        if (st.out_busy) state_next = S_TICK_CHECK;
        else if (st.empty || !st.head_zero) state_next = S_IDLE;
        else state_next = S_TICK_SHIFT;
      end
      S_TICK_SHIFT: if (st.shift_end) state_next = S_TICK_CHECK;
      S_OUT:       if (!st.out_busy) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_ADD_DONE:  cmd.add_check = 1'b1;
      S_ADD_WALK:  cmd.walk_step = 1'b1;
      S_ADD_SHIFT: begin
        cmd.shift_up = 1'b1;
        cmd.insert   = st.shift_end;
      end
      S_DEL_FIND:  cmd.find_step = 1'b1;
      S_DEL_FIX:   cmd.del_fix = 1'b1;
      S_DEL_SHIFT: cmd.shift_down = 1'b1;
      S_TICK_DEC:  cmd.tick_dec = !st.empty;
      S_TICK_CHECK: cmd.emit_wake = !st.out_busy && !st.empty && st.head_zero;
      S_TICK_SHIFT: cmd.shift_down = 1'b1;
      S_OUT:       cmd.emit_ack = !st.out_busy;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_emit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.emit_ack && cmd.emit_wake)) else $error("double emit");
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state != S_IDLE || $past(op) == OP_NONE) else $error("load lost");
`endif
endmodule
`default_nettype wire

// File: src/dltq_dp.sv
`default_nettype none
module dltq_dp #(
  parameter int MaxTimers = dltq_pkg::DefMaxTimers,
  parameter int TickBits  = dltq_pkg::DefTickBits
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dltq_pkg::cmd_t                cmd,
  output dltq_pkg::stat_t                    st,
  input  wire logic [1:0]                    op,
  input  wire logic [dltq_pkg::SlotBits-1:0] slot_in,
  input  wire logic [dltq_pkg::ProcBits-1:0] proc_in,
  input  wire logic [dltq_pkg::ExpiryBits-1:0] ticks_in,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_kind,
  output logic [1:0]                         out_status,
  output logic [dltq_pkg::SlotBits-1:0]      out_slot,
  output logic [dltq_pkg::ProcBits-1:0]      out_proc,
  output logic                               out_last
);
  import dltq_pkg::*;

  localparam int Depth = (MaxTimers < 16) ? MaxTimers : 16;
  localparam int LenW  = $clog2(Depth + 1);
  localparam int PosW  = (Depth > 1) ? $clog2(Depth) : 1;

  logic [SlotBits-1:0] order [Depth];
  logic [TickBits-1:0] delta [16];
  logic [ProcBits-1:0] owner [16];
  logic [15:0]         queued;
  logic [LenW-1:0]     len;

  logic [1:0]          r_op;
  logic [SlotBits-1:0] r_slot;
  logic [ProcBits-1:0] r_proc;
  logic [TickBits-1:0] e;
  logic [LenW-1:0]     pos;
  logic [LenW-1:0]     idx;
  status_t             rej;

  logic [TickBits-1:0] ext_ticks;
  logic [SlotBits-1:0] cur_slot, head_slot;
  logic [TickBits-1:0] cur_delta;

  assign ext_ticks = TickBits'(ticks_in);

  assign cur_slot  = order[pos[PosW-1:0]];
  assign head_slot = order[0];
  assign cur_delta = delta[cur_slot];

  assign st.queued    = queued[r_slot];
  assign st.zero_exp  = (e == '0);
  assign st.full      = (len >= LenW'(Depth));
  assign st.empty     = (len == '0);
  assign st.walk_end  = (pos >= len);
  assign st.walk_stop = (pos < len) && (e < cur_delta);
  assign st.find_hit  = (pos < len) && (cur_slot == r_slot);
  assign st.head_zero = (delta[head_slot] == '0);
  assign st.out_busy  = out_valid && !out_ready;
  assign st.shift_end = (r_op == OP_ADD) ? (idx <= pos) : (idx + 1'b1 >= len);

  always_ff @(posedge clk) begin
    if (rst) begin
      queued    <= '0;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && !cmd.emit_wake && !cmd.emit_ack) out_valid <= 1'b0;
      if (cmd.load) begin
        r_op <= op; r_slot <= slot_in; r_proc <= proc_in;
        e <= ext_ticks; pos <= '0;
      end
      if (cmd.walk_step && !st.walk_end) begin
        if (st.walk_stop) begin
          delta[cur_slot] <= cur_delta - e;
          idx <= len;
        end else begin
          e   <= e - cur_delta;
          pos <= pos + 1'b1;
        end
      end else if (cmd.walk_step) idx <= len;
      if (cmd.shift_up && !cmd.insert) begin
        order[idx[PosW-1:0]] <= order[idx[PosW-1:0] - 1'b1];
        idx <= idx - 1'b1;
      end
      if (cmd.insert) begin
        order[pos[PosW-1:0]] <= r_slot;
        delta[r_slot]  <= e;
        owner[r_slot]  <= r_proc;
        queued[r_slot] <= 1'b1;
        len <= len + 1'b1;
      end
      if (cmd.find_step && !st.find_hit && !st.walk_end) pos <= pos + 1'b1;
      if (cmd.del_fix) begin
        if (delta[r_slot] != '0 && pos + 1'b1 < len)
          delta[order[pos[PosW-1:0] + 1'b1]] <=
            delta[order[pos[PosW-1:0] + 1'b1]] + delta[r_slot];
        queued[r_slot] <= 1'b0;
        idx <= pos;
      end
      if (cmd.shift_down) begin
        if (idx + 1'b1 < len) begin
          order[idx[PosW-1:0]] <= order[idx[PosW-1:0] + 1'b1];
          idx <= idx + 1'b1;
        end else len <= len - 1'b1;
      end
      if (cmd.tick_dec && delta[head_slot] != '0)
        delta[head_slot] <= delta[head_slot] - 1'b1;
      if (cmd.emit_wake) begin
        queued[head_slot] <= 1'b0;
        idx <= '0;
        out_valid  <= 1'b1;
        out_kind   <= 1'b1;
        out_status <= ST_OK;
        out_slot   <= head_slot;
        out_proc   <= owner[head_slot];
        out_last   <= (len == LenW'(1)) ||
                      (delta[order[(Depth > 1) ? 1 : 0]] != '0);
      end
      if (cmd.emit_ack) begin
        out_valid <= 1'b1;
        out_kind  <= 1'b0;
        out_slot  <= r_slot;
        out_proc  <= '0;
        out_last  <= 1'b1;
        if (r_op == OP_ADD) out_status <= rej;
        else out_status <= ST_OK;
      end
    end
  end

  // add rejection status latched before walk
  always_ff @(posedge clk) begin
    if (cmd.add_check) begin
      if (st.zero_exp) rej <= ST_ZERO;
      else if (st.queued) rej <= ST_DUP;
      else if (st.full) rej <= ST_FULL;
      else rej <= ST_OK;
    end
  end

`ifndef NO_ASSERTIONS
  a_len: assert property (@(posedge clk) disable iff (rst)
    len <= LenW'(Depth)) else $error("length overflow");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    $countones(queued) == int'(len) || cmd.shift_down || $past(cmd.shift_down)
    || cmd.del_fix || $past(cmd.emit_wake) || cmd.emit_wake)
    else $error("queued count");
  a_wake: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_wake |-> !st.empty) else $error("wake on empty");
`endif
endmodule
`default_nettype wire

// File: src/delta_list_timer_queue_top.sv
`default_nettype none
// Add: check, walk the list, shift entries up, insert, ack; a rejected add goes to the ack.
// Delete: find the slot, fold its delta into the next entry, shift down, ack; an unqueued slot
// goes to the ack. Tick: decrement the head delta, then per expired head emit a wake and shift.
// Throughput: one request at a time; the ordered list is walked one entry per cycle.
// Reset: synchronous active-high rst empties the queue and clears all queued flags.
module delta_list_timer_queue_top #(
  parameter int MAX_TIMERS = dltq_pkg::DefMaxTimers,
  parameter int TICK_BITS  = dltq_pkg::DefTickBits
) (
  input wire logic clk,
  input wire logic rst,
  dltq_in_if.sink    in_ch,
  dltq_out_if.source out_ch
);
  import dltq_pkg::*;

  cmd_t  cmd;
  stat_t st;

  dltq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .op(in_ch.operation), .st(st), .cmd(cmd)
  );

  dltq_dp #(.MaxTimers(MAX_TIMERS), .TickBits(TICK_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .op(in_ch.operation), .slot_in(in_ch.timer_slot), .proc_in(in_ch.owner_process),
    .ticks_in(in_ch.expiry_ticks),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_kind(out_ch.kind),
    .out_status(out_ch.status), .out_slot(out_ch.expired_slot),
    .out_proc(out_ch.wake_process), .out_last(out_ch.last)
  );
endmodule
`default_nettype wire
